### design/ssrc_pkg.sv
package ssrc_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int SAMPLE_BITS = 12;
  localparam int CNT_BITS = $clog2(MAX_SAMPLES + 1);
  localparam int RANGE_BITS = 7;
  localparam int RANGE_MAX = 127;
  localparam int RCNT_BITS = (CNT_BITS > RANGE_BITS) ? CNT_BITS : RANGE_BITS;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last_sample;
  } in_item_t;

  typedef struct packed {
    logic [RANGE_BITS-1:0] range_count;
    logic                  overflow;
  } out_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last_sample;
    logic                   keep;
    logic                   overflow;
  } queue_entry_t;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_COUNT = 2'b10
  } back_state_t;

endpackage

### design/sorted_sample_range_counter.sv
// channel  valid      stall      payload
// input    in_valid   in_stall   in_item  (sample, last_sample)
// result   out_valid  out_stall  out_item (range_count, overflow)
//
// A sample is inserted into the sorted cell chain in the same cycle as it leaves the queue.
// After the last sample, the chain shifts out one cell a cycle; out_valid rises once only
// the first cell of the set is left in the chain and the result register is free.
// rst_n is synchronous; it empties the queue and the chain.
// Input transfers continue into the 4-entry queue while the chain drains or the
// result waits on out_stall; in_stall rises once the queue is full.
module sorted_sample_range_counter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ssrc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output ssrc_pkg::out_item_t out_item
);

  logic                   q_full;
  logic                   q_push;
  logic                   q_pop;
  logic                   q_nonempty;
  ssrc_pkg::queue_entry_t q_push_data;
  ssrc_pkg::queue_entry_t q_head;

  ssrc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  ssrc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .nonempty  (q_nonempty)
  );

  ssrc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_nonempty (q_nonempty),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

### design/ssrc_front.sv
module ssrc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ssrc_pkg::in_item_t    in_item,
  input  logic                  q_full,
  output logic                  q_push,
  output ssrc_pkg::queue_entry_t q_push_data
);

  logic [ssrc_pkg::CNT_BITS-1:0] fill_r, fill_nxt;
  logic                          ovf_r, ovf_nxt;
  logic                          keep;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign keep     = fill_r < ssrc_pkg::CNT_BITS'(ssrc_pkg::MAX_SAMPLES);

  always_comb begin
    q_push_data.sample      = in_item.sample;
    q_push_data.last_sample = in_item.last_sample;
    q_push_data.keep        = keep;
    q_push_data.overflow    = ovf_r || !keep;
  end

  always_comb begin
    fill_nxt = fill_r;
    ovf_nxt  = ovf_r;
    if (q_push) begin
      if (in_item.last_sample) begin
        fill_nxt = '0;
        ovf_nxt  = 1'b0;
      end else if (keep) begin
        fill_nxt = fill_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

### design/ssrc_queue.sv
module ssrc_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  ssrc_pkg::queue_entry_t push_data,
  output logic                   full,
  input  logic                   pop,
  output ssrc_pkg::queue_entry_t head,
  output logic                   nonempty
);

  ssrc_pkg::queue_entry_t          mem_r [ssrc_pkg::QUEUE_DEPTH];
  logic [ssrc_pkg::QPTR_BITS-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [ssrc_pkg::QCNT_BITS-1:0]  cnt_r, cnt_nxt;

  assign full     = cnt_r == ssrc_pkg::QCNT_BITS'(ssrc_pkg::QUEUE_DEPTH);
  assign nonempty = cnt_r != '0;
  assign head     = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### design/ssrc_back.sv
module ssrc_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ssrc_pkg::queue_entry_t head,
  input  logic                   q_nonempty,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ssrc_pkg::out_item_t    out_item
);

  localparam int N = ssrc_pkg::MAX_SAMPLES;

  ssrc_pkg::back_state_t            state_r, state_nxt;
  logic [ssrc_pkg::SAMPLE_BITS-1:0] cell_r   [N];
  logic [ssrc_pkg::SAMPLE_BITS-1:0] cell_nxt [N];
  logic [N-1:0]                     vld_r, vld_nxt;
  logic [N-1:0]                     gt;
  logic [ssrc_pkg::RCNT_BITS-1:0]   rcnt_r, rcnt_nxt;
  logic                             ovf_r, ovf_nxt;
  logic                             out_valid_r, out_valid_nxt;
  ssrc_pkg::out_item_t              out_item_r, out_item_nxt;
  logic                             out_free;
  logic                             insert;
  logic [ssrc_pkg::SAMPLE_BITS-1:0] gap;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = (state_r == ssrc_pkg::ST_LOAD) && q_nonempty;
  assign insert    = q_pop && head.keep;
  assign gap       = cell_r[1] - cell_r[0];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      gt[i] = !vld_r[i] || (cell_r[i] > head.sample);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    vld_nxt       = vld_r;
    rcnt_nxt      = rcnt_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    for (int i = 0; i < N; i++) begin
      cell_nxt[i] = cell_r[i];
    end
    case (state_r)
      ssrc_pkg::ST_LOAD: begin
        if (insert) begin
          for (int i = 0; i < N; i++) begin
            if (gt[i]) begin
              if (i == 0) begin
                cell_nxt[i] = head.sample;
                vld_nxt[i]  = 1'b1;
              end else if (!gt[i-1]) begin
                cell_nxt[i] = head.sample;
                vld_nxt[i]  = 1'b1;
              end else begin
                cell_nxt[i] = cell_r[i-1];
                vld_nxt[i]  = vld_r[i-1];
              end
            end
          end
        end
        if (q_pop && head.last_sample) begin
          ovf_nxt   = head.overflow;
          rcnt_nxt  = ssrc_pkg::RCNT_BITS'(1);
          state_nxt = ssrc_pkg::ST_COUNT;
        end
      end
      ssrc_pkg::ST_COUNT: begin
        if (vld_r[1]) begin
          if (gap > ssrc_pkg::SAMPLE_BITS'(1)) begin
            rcnt_nxt = rcnt_r + 1'b1;
          end
          for (int i = 0; i < N - 1; i++) begin
            cell_nxt[i] = cell_r[i+1];
            vld_nxt[i]  = vld_r[i+1];
          end
          vld_nxt[N-1] = 1'b0;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt.overflow = ovf_r;
          if (rcnt_r > ssrc_pkg::RCNT_BITS'(ssrc_pkg::RANGE_MAX)) begin
            out_item_nxt.range_count = ssrc_pkg::RANGE_BITS'(ssrc_pkg::RANGE_MAX);
          end else begin
            out_item_nxt.range_count = rcnt_r[ssrc_pkg::RANGE_BITS-1:0];
          end
          vld_nxt[0] = 1'b0;
          state_nxt  = ssrc_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = ssrc_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
    rcnt_r     <= rcnt_nxt;
    ovf_r      <= ovf_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssrc_pkg::ST_LOAD;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### verif/sorted_sample_range_counter_tb.sv
`timescale 1ns / 1ps

module sorted_sample_range_counter_tb;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_ITEMS = 1100;
  localparam logic [ssrc_pkg::SAMPLE_BITS-1:0] SAMPLE_TOP = {ssrc_pkg::SAMPLE_BITS{1'b1}};

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  ssrc_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ssrc_pkg::out_item_t out_item;

  sorted_sample_range_counter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // shadow of the block's set under load
  logic [ssrc_pkg::SAMPLE_BITS-1:0] held_samples [ssrc_pkg::MAX_SAMPLES];
  int                               held_n = 0;
  logic                             held_dropped = 1'b0;

  ssrc_pkg::out_item_t pending_counts [$];
  int                  mismatches = 0;
  int                  burst_left = 0;
  int                  idle_cycles = 0;
  logic [15:0]         stall_cycle = '0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ranges = maximal runs of consecutive values present in the set
  function automatic logic [ssrc_pkg::RANGE_BITS-1:0] range_count_of(
      input logic [ssrc_pkg::SAMPLE_BITS-1:0] vals [ssrc_pkg::MAX_SAMPLES], input int n);
    bit present [1 << ssrc_pkg::SAMPLE_BITS];
    int runs;
    runs = 0;
    for (int i = 0; i < n; i++) present[vals[i]] = 1'b1;
    for (int v = 0; v < (1 << ssrc_pkg::SAMPLE_BITS); v++) begin
      if (present[v] && (v == 0 || !present[v-1])) runs++;
    end
    if (runs > ssrc_pkg::RANGE_MAX) runs = ssrc_pkg::RANGE_MAX;
    return runs[ssrc_pkg::RANGE_BITS-1:0];
  endfunction

  task automatic send_sample(input logic [ssrc_pkg::SAMPLE_BITS-1:0] s, input logic last);
    int gap;
    ssrc_pkg::out_item_t exp_item;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    in_item <= '{sample: s, last_sample: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (held_n < ssrc_pkg::MAX_SAMPLES) begin
      held_samples[held_n] = s;
      held_n++;
    end else begin
      held_dropped = 1'b1;
    end
    if (last) begin
      exp_item.range_count = range_count_of(held_samples, held_n);
      exp_item.overflow = held_dropped;
      pending_counts.push_back(exp_item);
      held_n = 0;
      held_dropped = 1'b0;
    end
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_counts.size() != 0) @(posedge clk);
  endtask

  task automatic test_single_sample_sets();
    send_sample('0, 1'b1);
    send_sample(SAMPLE_TOP, 1'b1);
    send_sample(12'hAAA, 1'b1);
  endtask

  task automatic test_range_boundaries();
    send_sample('0, 1'b0);
    send_sample(SAMPLE_TOP, 1'b1);
    repeat (2) send_sample(12'd5, 1'b0);
    send_sample(12'd5, 1'b1);
    send_sample(12'd10, 1'b0);
    send_sample(12'd9, 1'b0);
    send_sample(12'd8, 1'b0);
    send_sample(12'd7, 1'b1);
    send_sample(12'd1, 1'b0);
    send_sample(12'd3, 1'b1);
    send_sample(SAMPLE_TOP, 1'b0);
    send_sample(SAMPLE_TOP - 12'd1, 1'b0);
    send_sample('0, 1'b0);
    send_sample(12'd1, 1'b1);
    send_sample(12'h555, 1'b0);
    send_sample(12'hAAA, 1'b1);
  endtask

  // full store of isolated values, then a marked sample that is dropped
  task automatic test_store_overflow();
    for (int i = 0; i < ssrc_pkg::MAX_SAMPLES; i++) send_sample(12'(i * 3), 1'b0);
    send_sample(12'd2000, 1'b1);
    send_sample(12'd7, 1'b1);
  endtask

  task automatic test_pause_until_drained();
    send_sample(12'd100, 1'b0);
    send_sample(12'd101, 1'b1);
    wait_results_drained();
    send_sample(12'd300, 1'b0);
    send_sample(12'd302, 1'b1);
  endtask

  task automatic test_random_sets();
    int sent;
    int pick;
    int len;
    int mode;
    int base;
    int span;
    int v;
    logic [ssrc_pkg::SAMPLE_BITS-1:0] s;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) len = $urandom_range(ssrc_pkg::MAX_SAMPLES, ssrc_pkg::MAX_SAMPLES + 8);
      else if (pick < 3) len = $urandom_range(40, ssrc_pkg::MAX_SAMPLES);
      else len = $urandom_range(1, 12);
      mode = $urandom_range(0, 2);
      base = $urandom_range(0, 4095);
      span = $urandom_range(1, 24);
      for (int i = 0; i < len; i++) begin
        case (mode)
          0: s = 12'($urandom_range(0, 4095));
          1: begin
            v = base + $urandom_range(0, span);
            s = (v > 4095) ? SAMPLE_TOP : 12'(v);
          end
          default: s = $urandom_range(0, 1) ? 12'($urandom_range(0, 3))
                                            : SAMPLE_TOP - 12'($urandom_range(0, 3));
        endcase
        send_sample(s, i == len - 1);
      end
      sent += len;
      if ($urandom_range(0, 39) == 0) wait_results_drained();
    end
  endtask

  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1'b1;
    case (stall_cycle[9:8])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_cycle[2:0] < 3'd3);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_counts.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual range_count %0d overflow %0b",
                 $time, out_item.range_count, out_item.overflow);
        mismatches++;
      end else begin
        if (out_item.range_count !== pending_counts[0].range_count) begin
          $display("%0t: range_count: expected %0d, actual %0d",
                   $time, pending_counts[0].range_count, out_item.range_count);
          mismatches++;
        end
        if (out_item.overflow !== pending_counts[0].overflow) begin
          $display("%0t: overflow: expected %0b, actual %0b",
                   $time, pending_counts[0].overflow, out_item.overflow);
          mismatches++;
        end
        void'(pending_counts.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_sample_sets();
    test_range_boundaries();
    test_store_overflow();
    test_pause_until_drained();
    test_random_sets();
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    foreach (pending_counts[i]) begin
      $display("%0t: missing result: expected range_count %0d overflow %0b, actual none",
               $time, pending_counts[i].range_count, pending_counts[i].overflow);
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
